>>> sv/ccmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccmc_pkg
// Shared types, register indexes and reset values of the chamber mode
// controller.
// ----------------------------------------------------------------------------
package ccmc_pkg;

    localparam int TIME_W  = 32;
    localparam int TEMP_W  = 11;
    localparam int HUM_W   = 10;
    localparam int CODE_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    localparam logic [TIME_W-1:0] C_MAX_COOL_RUN_MS  = 32'd600000;
    localparam logic [TIME_W-1:0] C_MAX_HEAT_RUN_MS  = 32'd600000;
    localparam logic [TIME_W-1:0] C_MAX_HUMID_RUN_MS = 32'd600000;

    localparam logic [TEMP_W-1:0] C_TEMP_UPPER_RST  = 11'sd250;
    localparam logic [TEMP_W-1:0] C_TEMP_LOWER_RST  = 11'sd180;
    localparam logic [HUM_W-1:0]  C_HUM_LOWER_RST   = 10'd850;
    localparam logic [TIME_W-1:0] C_SETTLE_RST      = 32'd5000;
    localparam logic [TIME_W-1:0] C_VENT_DUR_RST    = 32'd60000;
    localparam logic [TIME_W-1:0] C_COOLER_REST_RST = 32'd300000;
    localparam logic [TIME_W-1:0] C_HEATER_REST_RST = 32'd300000;
    localparam logic [TIME_W-1:0] C_HUMID_REST_RST  = 32'd300000;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_UPPER   = 3'd0,
        CFG_TEMP_LOWER   = 3'd1,
        CFG_HUM_LOWER    = 3'd2,
        CFG_SETTLE       = 3'd3,
        CFG_VENT_DUR     = 3'd4,
        CFG_COOLER_REST  = 3'd5,
        CFG_HEATER_REST  = 3'd6,
        CFG_HUMID_REST   = 3'd7
    } t_cfg_idx;

    // Controller state, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_COOL  = 5'b00010,
        MODE_HEAT  = 5'b00100,
        MODE_HUMID = 5'b01000,
        MODE_VENT  = 5'b10000
    } t_mode;

    // Mode codes as they appear on the output
    localparam logic [CODE_W-1:0] CODE_IDLE  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_COOL  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_HEAT  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_HUMID = 3'd3;
    localparam logic [CODE_W-1:0] CODE_VENT  = 3'd4;

    typedef struct packed {
        logic [TEMP_W-1:0] temp_upper_limit;
        logic [TEMP_W-1:0] temp_lower_limit;
        logic [HUM_W-1:0]  humidity_lower_limit;
        logic [TIME_W-1:0] settle_delay_ms;
        logic [TIME_W-1:0] vent_duration_ms;
        logic [TIME_W-1:0] cooler_rest_ms;
        logic [TIME_W-1:0] heater_rest_ms;
        logic [TIME_W-1:0] humidifier_rest_ms;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]  humidity;
        logic              force_vent;
        logic              vent_due;
    } t_item;

    typedef struct packed {
        logic [CODE_W-1:0] mode;
        logic              peltier_on;
        logic              peltier_heat;
        logic              fan_on;
        logic              flap_open;
        logic              humidifier_on;
        logic [TEMP_W-1:0] held_temperature;
        logic [HUM_W-1:0]  held_humidity;
        logic              settling;
    } t_result;

    function automatic logic [CODE_W-1:0] mode_code(input t_mode m);
        logic [CODE_W-1:0] c;
        case (m)
            MODE_COOL:  c = CODE_COOL;
            MODE_HEAT:  c = CODE_HEAT;
            MODE_HUMID: c = CODE_HUMID;
            MODE_VENT:  c = CODE_VENT;
            default:    c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> sv/ccmc_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccmc_cfg_regs
// Configuration register file: limits, settle delay, vent length and rest
// times, written by index.
// ----------------------------------------------------------------------------
module ccmc_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ccmc_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [ccmc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output ccmc_pkg::t_cfg                         o_cfg
);

    ccmc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_upper_limit     <= ccmc_pkg::C_TEMP_UPPER_RST;
            r_cfg.temp_lower_limit     <= ccmc_pkg::C_TEMP_LOWER_RST;
            r_cfg.humidity_lower_limit <= ccmc_pkg::C_HUM_LOWER_RST;
            r_cfg.settle_delay_ms      <= ccmc_pkg::C_SETTLE_RST;
            r_cfg.vent_duration_ms     <= ccmc_pkg::C_VENT_DUR_RST;
            r_cfg.cooler_rest_ms       <= ccmc_pkg::C_COOLER_REST_RST;
            r_cfg.heater_rest_ms       <= ccmc_pkg::C_HEATER_REST_RST;
            r_cfg.humidifier_rest_ms   <= ccmc_pkg::C_HUMID_REST_RST;
        end else if (i_cfg_we) begin
            case (ccmc_pkg::t_cfg_idx'(i_cfg_addr))
                ccmc_pkg::CFG_TEMP_UPPER: begin
                    r_cfg.temp_upper_limit <= i_cfg_wdata[ccmc_pkg::TEMP_W-1:0];
                end
                ccmc_pkg::CFG_TEMP_LOWER: begin
                    r_cfg.temp_lower_limit <= i_cfg_wdata[ccmc_pkg::TEMP_W-1:0];
                end
                ccmc_pkg::CFG_HUM_LOWER: begin
                    r_cfg.humidity_lower_limit <= i_cfg_wdata[ccmc_pkg::HUM_W-1:0];
                end
                ccmc_pkg::CFG_SETTLE:      r_cfg.settle_delay_ms    <= i_cfg_wdata;
                ccmc_pkg::CFG_VENT_DUR:    r_cfg.vent_duration_ms   <= i_cfg_wdata;
                ccmc_pkg::CFG_COOLER_REST: r_cfg.cooler_rest_ms     <= i_cfg_wdata;
                ccmc_pkg::CFG_HEATER_REST: r_cfg.heater_rest_ms     <= i_cfg_wdata;
                ccmc_pkg::CFG_HUMID_REST:  r_cfg.humidifier_rest_ms <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> sv/ccmc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccmc_ctrl
// Mode state machine: timestamps, rest bookkeeping and held samples, with
// the single-pass next-state and result logic for one sample.
// ----------------------------------------------------------------------------
module ccmc_ctrl #(
    parameter logic [ccmc_pkg::TIME_W-1:0] MAX_COOL_RUN_MS  = ccmc_pkg::C_MAX_COOL_RUN_MS,
    parameter logic [ccmc_pkg::TIME_W-1:0] MAX_HEAT_RUN_MS  = ccmc_pkg::C_MAX_HEAT_RUN_MS,
    parameter logic [ccmc_pkg::TIME_W-1:0] MAX_HUMID_RUN_MS = ccmc_pkg::C_MAX_HUMID_RUN_MS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire ccmc_pkg::t_cfg  i_cfg,
    input  wire ccmc_pkg::t_item i_item,
    output ccmc_pkg::t_result o_result
);

    ccmc_pkg::t_mode r_mode, n_mode;
    logic [ccmc_pkg::TIME_W-1:0] r_mode_change, n_mode_change;
    logic [ccmc_pkg::TIME_W-1:0] r_cool_start, n_cool_start;
    logic [ccmc_pkg::TIME_W-1:0] r_heat_start, n_heat_start;
    logic [ccmc_pkg::TIME_W-1:0] r_humid_start, n_humid_start;
    logic [ccmc_pkg::TIME_W-1:0] r_cooler_end, n_cooler_end;
    logic [ccmc_pkg::TIME_W-1:0] r_heater_end, n_heater_end;
    logic [ccmc_pkg::TIME_W-1:0] r_humid_end, n_humid_end;
    logic                        r_pending, n_pending;
    logic [ccmc_pkg::TEMP_W-1:0] r_last_temp, n_last_temp;
    logic [ccmc_pkg::HUM_W-1:0]  r_last_hum, n_last_hum;

    logic [ccmc_pkg::TIME_W-1:0] now;
    logic [ccmc_pkg::TIME_W-1:0] el_mode, el_cool, el_heat, el_humid;
    logic [ccmc_pkg::TIME_W-1:0] el_cooler_rest, el_heater_rest, el_humid_rest;
    logic temp_hot, temp_cold, hum_dry, hum_wet;
    logic pending_set, settling;

    // Wrapping elapsed times
    assign now            = i_item.now_ms;
    assign el_mode        = now - r_mode_change;
    assign el_cool        = now - r_cool_start;
    assign el_heat        = now - r_heat_start;
    assign el_humid       = now - r_humid_start;
    assign el_cooler_rest = now - r_cooler_end;
    assign el_heater_rest = now - r_heater_end;
    assign el_humid_rest  = now - r_humid_end;

    assign temp_hot  = $signed(i_item.temperature) >= $signed(i_cfg.temp_upper_limit);
    assign temp_cold = $signed(i_item.temperature) <= $signed(i_cfg.temp_lower_limit);
    assign hum_dry   = i_item.humidity < i_cfg.humidity_lower_limit;
    assign hum_wet   = i_item.humidity > i_cfg.humidity_lower_limit;

    assign pending_set = r_pending | i_item.force_vent;
    assign settling    = (r_mode == ccmc_pkg::MODE_IDLE) && (el_mode < i_cfg.settle_delay_ms);

    always_comb begin
        n_mode        = r_mode;
        n_mode_change = r_mode_change;
        n_cool_start  = r_cool_start;
        n_heat_start  = r_heat_start;
        n_humid_start = r_humid_start;
        n_cooler_end  = r_cooler_end;
        n_heater_end  = r_heater_end;
        n_humid_end   = r_humid_end;
        n_pending     = pending_set;
        n_last_temp   = r_last_temp;
        n_last_hum    = r_last_hum;
        if (!settling) begin
            n_last_temp = i_item.temperature;
            n_last_hum  = i_item.humidity;
            case (r_mode)
                ccmc_pkg::MODE_IDLE: begin
                    if (pending_set || i_item.vent_due) begin
                        n_mode        = ccmc_pkg::MODE_VENT;
                        n_mode_change = now;
                        n_pending     = 1'b0;
                    end else if (temp_hot && el_cooler_rest >= i_cfg.cooler_rest_ms) begin
                        n_mode        = ccmc_pkg::MODE_COOL;
                        n_cool_start  = now;
                        n_mode_change = now;
                    end else if (temp_cold && el_heater_rest >= i_cfg.heater_rest_ms) begin
                        n_mode        = ccmc_pkg::MODE_HEAT;
                        n_heat_start  = now;
                        n_mode_change = now;
                    end else if (hum_dry && el_humid_rest >= i_cfg.humidifier_rest_ms) begin
                        n_mode        = ccmc_pkg::MODE_HUMID;
                        n_humid_start = now;
                        n_mode_change = now;
                    end
                end
                ccmc_pkg::MODE_VENT: begin
                    if (el_mode >= i_cfg.vent_duration_ms) begin
                        n_mode        = ccmc_pkg::MODE_IDLE;
                        n_mode_change = now;
                    end
                end
                ccmc_pkg::MODE_COOL: begin
                    if (!temp_hot || el_cool >= MAX_COOL_RUN_MS) begin
                        n_cooler_end  = now;
                        n_mode        = ccmc_pkg::MODE_IDLE;
                        n_mode_change = now;
                    end
                end
                ccmc_pkg::MODE_HEAT: begin
                    if (!temp_cold || el_heat >= MAX_HEAT_RUN_MS) begin
                        n_heater_end  = now;
                        n_mode        = ccmc_pkg::MODE_IDLE;
                        n_mode_change = now;
                    end
                end
                ccmc_pkg::MODE_HUMID: begin
                    if (hum_wet || el_humid >= MAX_HUMID_RUN_MS) begin
                        n_humid_end   = now;
                        n_mode        = ccmc_pkg::MODE_IDLE;
                        n_mode_change = now;
                    end
                end
                default: begin
                    n_mode        = ccmc_pkg::MODE_IDLE;
                    n_mode_change = now;
                end
            endcase
        end
    end

    // Result reflects the state after this sample
    always_comb begin
        o_result.mode             = ccmc_pkg::mode_code(n_mode);
        o_result.peltier_on       = (n_mode == ccmc_pkg::MODE_COOL) ||
                                    (n_mode == ccmc_pkg::MODE_HEAT);
        o_result.peltier_heat     = (n_mode == ccmc_pkg::MODE_HEAT);
        o_result.fan_on           = (n_mode == ccmc_pkg::MODE_VENT);
        o_result.flap_open        = (n_mode == ccmc_pkg::MODE_VENT);
        o_result.humidifier_on    = (n_mode == ccmc_pkg::MODE_HUMID);
        o_result.held_temperature = n_last_temp;
        o_result.held_humidity    = n_last_hum;
        o_result.settling         = settling;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ccmc_pkg::MODE_IDLE;
            r_mode_change <= '0;
            r_cool_start  <= '0;
            r_heat_start  <= '0;
            r_humid_start <= '0;
            r_cooler_end  <= '0;
            r_heater_end  <= '0;
            r_humid_end   <= '0;
            r_pending     <= 1'b0;
            r_last_temp   <= '0;
            r_last_hum    <= '0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_mode_change <= n_mode_change;
            r_cool_start  <= n_cool_start;
            r_heat_start  <= n_heat_start;
            r_humid_start <= n_humid_start;
            r_cooler_end  <= n_cooler_end;
            r_heater_end  <= n_heater_end;
            r_humid_end   <= n_humid_end;
            r_pending     <= n_pending;
            r_last_temp   <= n_last_temp;
            r_last_hum    <= n_last_hum;
        end
    end

endmodule
`default_nettype wire

>>> sv/climate_chamber_mode_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// climate_chamber_mode_controller
// Five-mode chamber controller (idle, cooling, heating, humidifying,
// ventilating) driven by timestamped sensor samples.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Content
//  s_axis    in         tvalid/tready               one sensor sample per transfer
//  m_axis    out        tvalid/tready               mode, actuators, held samples
//  cfg       in         i_cfg_we (no back-pressure) register index + write data
//
//  A sample goes from the input register through the mode logic into the
//  result register. One sample per cycle is sustained while m_axis_tready
//  stays high; the mode state registers update only when a sample moves
//  from the input register into the result register.
//  Reset (i_rst_n low, synchronous) empties both stages, restores the
//  register defaults and puts the controller in idle with all times at zero.
//  While m_axis is stalled the result holds; one more sample may wait in the
//  input register, then s_axis_tready drops.
//
module climate_chamber_mode_controller #(
    parameter logic [ccmc_pkg::TIME_W-1:0] MAX_COOL_RUN_MS  = ccmc_pkg::C_MAX_COOL_RUN_MS,
    parameter logic [ccmc_pkg::TIME_W-1:0] MAX_HEAT_RUN_MS  = ccmc_pkg::C_MAX_HEAT_RUN_MS,
    parameter logic [ccmc_pkg::TIME_W-1:0] MAX_HUMID_RUN_MS = ccmc_pkg::C_MAX_HUMID_RUN_MS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [ccmc_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [ccmc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // sample stream
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // now_ms[31:0], temperature[42:32], humidity[52:43], force_vent[53],
    // vent_due[54], zero[55]
    input  wire logic [ccmc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // result stream
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // mode[2:0], peltier_on[3], peltier_heat[4], fan_on[5], flap_open[6],
    // humidifier_on[7], held_temperature[18:8], held_humidity[28:19],
    // settling[29], zero[31:30]
    output      logic [ccmc_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    localparam int RES_W = $bits(ccmc_pkg::t_result);

    ccmc_pkg::t_cfg    cfg;
    ccmc_pkg::t_item   r_in_item;
    ccmc_pkg::t_result step_result;
    ccmc_pkg::t_result r_out;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              advance;
    logic              fire;

    // Result register frees up when empty or when its transfer completes
    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    ccmc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ccmc_ctrl #(
        .MAX_COOL_RUN_MS  (MAX_COOL_RUN_MS),
        .MAX_HEAT_RUN_MS  (MAX_HEAT_RUN_MS),
        .MAX_HUMID_RUN_MS (MAX_HUMID_RUN_MS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cfg    (cfg),
        .i_item   (r_in_item),
        .o_result (step_result)
    );

    // Input stage: take a transfer whenever the stage is empty or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.now_ms      <= s_axis_tdata[31:0];
            r_in_item.temperature <= s_axis_tdata[42:32];
            r_in_item.humidity    <= s_axis_tdata[52:43];
            r_in_item.force_vent  <= s_axis_tdata[53];
            r_in_item.vent_due    <= s_axis_tdata[54];
        end
    end

    // Result stage: hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        m_axis_tdata        = '0;
        m_axis_tdata[2:0]   = r_out.mode;
        m_axis_tdata[3]     = r_out.peltier_on;
        m_axis_tdata[4]     = r_out.peltier_heat;
        m_axis_tdata[5]     = r_out.fan_on;
        m_axis_tdata[6]     = r_out.flap_open;
        m_axis_tdata[7]     = r_out.humidifier_on;
        m_axis_tdata[18:8]  = r_out.held_temperature;
        m_axis_tdata[28:19] = r_out.held_humidity;
        m_axis_tdata[RES_W-1] = r_out.settling;
    end

endmodule
`default_nettype wire
